// File: hw/rtl/pca_pkg.sv
// shared constants, types and helper functions for the polar complex alu
package pca_pkg;

  // rotation / vectoring iterations
  localparam int CORDIC_STAGES       = 24;
  localparam int ATAN_ENTRIES        = 30;
  localparam int NSTG                = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES :
                                       CORDIC_STAGES;
  localparam int EQUAL_TOLERANCE_LSB = 4;

  // datapath widths
  localparam int XW       = 52;   // cordic x and y, q.30
  localparam int ZW       = 36;   // cordic angle, q.30
  localparam int RW       = 35;   // reduced angle, q.30
  localparam int DIV_BITS = 48;   // quotient bits of the radius divide

  // operation codes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_NEG   = 3'd4;
  localparam logic [2:0] OP_EQUAL = 3'd5;

  localparam logic [29:0]          K_Q30       = 30'd652032874;
  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [32:0]   PI_Q26      = 33'sd210828714;
  localparam logic signed [31:0]   TWO_PI_Q26  = 32'sd421657428;
  localparam logic [31:0]          ONE_Q16     = 32'd65536;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cvec_t;

  typedef struct packed {
    logic [31:0]         rem;
    logic [DIV_BITS-1:0] dq;
    logic [31:0]         dvs;
  } dstep_t;

  // per stage sideband of one transaction
  typedef struct packed {
    logic               valid;
    logic [2:0]         kind;
    logic [31:0]        rad;
    logic signed [31:0] ang;
    logic               sat;
    logic               dz;
    logic               eq;
    logic               rmatch;
    logic               flip_a;
    logic               flip_b;
    logic               vzero;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 36'sh03243F6A8;
      5'd1:    v = 36'sh01DAC6705;
      5'd2:    v = 36'sh00FADBAFC;
      5'd3:    v = 36'sh007F56EA6;
      5'd4:    v = 36'sh003FEAB76;
      5'd5:    v = 36'sh001FFD55B;
      5'd6:    v = 36'sh000FFFAAA;
      5'd7:    v = 36'sh0007FFF55;
      5'd8:    v = 36'sh0003FFFEA;
      5'd9:    v = 36'sh0001FFFFD;
      5'd10:   v = 36'sh0000FFFFF;
      5'd11:   v = 36'sh00007FFFF;
      5'd12:   v = 36'sh00003FFFF;
      5'd13:   v = 36'sh00001FFFF;
      5'd14:   v = 36'sh00000FFFF;
      5'd15:   v = 36'sh000007FFF;
      5'd16:   v = 36'sh000003FFF;
      5'd17:   v = 36'sh000001FFF;
      5'd18:   v = 36'sh000000FFF;
      5'd19:   v = 36'sh0000007FF;
      5'd20:   v = 36'sh0000003FF;
      5'd21:   v = 36'sh0000001FF;
      5'd22:   v = 36'sh0000000FF;
      5'd23:   v = 36'sh00000007F;
      5'd24:   v = 36'sh00000003F;
      5'd25:   v = 36'sh00000001F;
      5'd26:   v = 36'sh00000000F;
      5'd27:   v = 36'sh000000008;
      5'd28:   v = 36'sh000000004;
      5'd29:   v = 36'sh000000002;
      default: v = '0;
    endcase
    return v;
  endfunction

  // truncating remainder of angle*16 by two pi; quotient never exceeds five
  function automatic logic signed [RW-1:0] reduce_q30(input logic signed [31:0] a);
    logic [35:0] z;
    logic [35:0] az;
    logic [35:0] m;
    logic [35:0] r;
    z  = {a, 4'b0000};
    az = a[31] ? (~z + 36'd1) : z;
    if (az >= 36'd33732594260)      m = 36'd33732594260;
    else if (az >= 36'd26986075408) m = 36'd26986075408;
    else if (az >= 36'd20239556556) m = 36'd20239556556;
    else if (az >= 36'd13493037704) m = 36'd13493037704;
    else if (az >= 36'd6746518852)  m = 36'd6746518852;
    else                            m = '0;
    r = az - m;
    if (a[31]) r = ~r + 36'd1;
    return r[RW-1:0];
  endfunction

  // fold into [-pi/2, pi/2]; top bit flags the half turn
  function automatic logic [ZW:0] fold_q30(input logic signed [RW-1:0] a);
    logic signed [ZW-1:0] zz;
    logic                 flip;
    zz   = {{(ZW-RW){a[RW-1]}}, a};
    flip = 1'b0;
    if (zz > PI_Q30) zz = zz - TWO_PI_Q30;
    if (zz < -PI_Q30) zz = zz + TWO_PI_Q30;
    if (zz > HALF_PI_Q30) begin
      zz   = zz - PI_Q30;
      flip = 1'b1;
    end else if (zz < -HALF_PI_Q30) begin
      zz   = zz + PI_Q30;
      flip = 1'b1;
    end
    return {flip, zz};
  endfunction

  function automatic logic ang_over(input logic signed [32:0] a);
    return a[32] != a[31];
  endfunction

  function automatic logic signed [31:0] clamp_ang(input logic signed [32:0] a);
    logic signed [31:0] v;
    if (a[32] != a[31]) v = a[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    else                v = a[31:0];
    return v;
  endfunction

endpackage

// File: hw/rtl/pca_cordic_cell.sv
// one cordic iteration, rotation or vectoring, with its output register
module pca_cordic_cell import pca_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic       vector_mode,
  input  logic [4:0] idx,
  input  cvec_t      d,
  output cvec_t      q
);

  cvec_t                nxt;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] at;
  logic                 down;

  always_comb begin
    dx   = d.y >>> idx;
    dy   = d.x >>> idx;
    at   = atan_q30(idx);
    down = vector_mode ? d.y[XW-1] : !d.z[ZW-1];
    if (down) begin
      nxt.x = d.x - dx;
      nxt.y = d.y + dy;
      nxt.z = d.z - at;
    end else begin
      nxt.x = d.x + dx;
      nxt.y = d.y - dy;
      nxt.z = d.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule

// File: hw/rtl/pca_div_cell.sv
// one restoring division step, one quotient bit, with its output register
module pca_div_cell import pca_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  dstep_t d,
  output dstep_t q
);

  dstep_t      nxt;
  logic [32:0] t;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    t       = {d.rem, d.dq[DIV_BITS-1]};
    diff    = t - {1'b0, d.dvs};
    ge      = t >= {1'b0, d.dvs};
    nxt.rem = ge ? diff[31:0] : t[31:0];
    nxt.dq  = {d.dq[DIV_BITS-2:0], ge};
    nxt.dvs = d.dvs;
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule

// File: hw/rtl/polar_complex_alu.sv
// polar complex alu: cordic and divider cell chains with a sideband pipeline
// the result stage is the later of the cordic path, two cordic chains in series,
//   and the 48 cell radius divider
// throughput: one transaction per cycle; the whole pipeline holds while a result is stalled
// reset: synchronous, clears the stage valid bits only; no clearing pass
module polar_complex_alu import pca_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  output logic               op_stall,
  input  logic [2:0]         kind,
  input  logic [31:0]        radius_a,
  input  logic signed [31:0] angle_a,
  input  logic [31:0]        radius_b,
  input  logic signed [31:0] angle_b,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [31:0]        result_radius,
  output logic signed [31:0] result_angle,
  output logic               is_equal,
  output logic               div_by_zero,
  output logic               angle_extended,
  output logic               saturated
);

  // stage positions, counted in registers after the input register
  localparam int N       = NSTG;
  localparam int POS_CMB = N + 3;          // flip applied, vectors summed
  localparam int POS_PRE = N + 4;          // vectoring start
  localparam int CORD_AT = 2 * N + 5;      // magnitude scaled
  localparam int DIV_AT  = DIV_BITS + 1;   // quotient clamped
  localparam int LAT     = (CORD_AT > DIV_AT) ? CORD_AT : DIV_AT;

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        ra;
    logic signed [31:0] aa;
    logic [31:0]        rb;
    logic signed [31:0] ab;
  } opnd_t;

  logic  en;
  logic  in_v;
  opnd_t in_q;

  side_t sd      [1:LAT];
  side_t sd_next [1:LAT];
  side_t s1_next;

  // global advance: everything moves unless the result register is held
  assign en       = !(sd[LAT].valid && res_stall);
  assign op_stall = !en;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (en) begin
      in_v <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) in_q <= '{kind: kind, ra: radius_a, aa: angle_a, rb: radius_b, ab: angle_b};
  end

  // stage 1: short operations finished here, angles reduced for the cordic
  logic [63:0]          mprod;
  logic signed [32:0]   msum;
  logic signed [32:0]   ddiff;
  logic signed [32:0]   nsum;
  logic signed [32:0]   rdiff;
  logic [32:0]          rabs;
  logic signed [RW-1:0] za1;
  logic signed [RW-1:0] zb1;
  logic [31:0]          rsa1;
  logic [31:0]          rsb1;

  always_comb begin
    mprod = in_q.ra * in_q.rb;
    msum  = {in_q.aa[31], in_q.aa} + {in_q.ab[31], in_q.ab};
    ddiff = {in_q.aa[31], in_q.aa} - {in_q.ab[31], in_q.ab};
    nsum  = {in_q.aa[31], in_q.aa} + PI_Q26;
    rdiff = {1'b0, in_q.ra} - {1'b0, in_q.rb};
    rabs  = rdiff[32] ? (~rdiff + 33'd1) : rdiff;
    s1_next       = '0;
    s1_next.valid = in_v;
    s1_next.kind  = in_q.kind;
    unique case (in_q.kind)
      OP_MUL: begin
        s1_next.rad = (|mprod[63:48]) ? 32'hFFFFFFFF : mprod[47:16];
        s1_next.ang = clamp_ang(msum);
        s1_next.sat = (|mprod[63:48]) || ang_over(msum);
      end
      OP_DIV: begin
        s1_next.dz = in_q.rb == '0;
        if (in_q.rb != '0) begin
          s1_next.ang = clamp_ang(ddiff);
          s1_next.sat = ang_over(ddiff);
        end
      end
      OP_NEG: begin
        s1_next.rad = in_q.ra;
        s1_next.ang = clamp_ang(nsum);
        s1_next.sat = ang_over(nsum);
      end
      OP_EQUAL: begin
        s1_next.rmatch = rabs <= 33'(EQUAL_TOLERANCE_LSB);
      end
      default: begin
        s1_next.rmatch = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      za1  <= reduce_q30(in_q.aa);
      zb1  <= reduce_q30(in_q.ab);
      // equal compares unit vectors
      rsa1 <= (in_q.kind == OP_EQUAL) ? ONE_Q16 : in_q.ra;
      rsb1 <= (in_q.kind == OP_EQUAL) ? ONE_Q16 : in_q.rb;
    end
  end

  // stage 2: fold to the right half plane, prescale radius by the cordic gain
  logic [ZW:0] fa;
  logic [ZW:0] fb;
  logic [61:0] xpa;
  logic [61:0] xpb;
  cvec_t       rot_a [0:N];
  cvec_t       rot_b [0:N];

  always_comb begin
    fa  = fold_q30(za1);
    fb  = fold_q30(zb1);
    xpa = rsa1 * K_Q30;
    xpb = rsb1 * K_Q30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_a[0] <= '{x: {{(XW-46){1'b0}}, xpa[61:16]}, y: '0, z: fa[ZW-1:0]};
      rot_b[0] <= '{x: {{(XW-46){1'b0}}, xpb[61:16]}, y: '0, z: fb[ZW-1:0]};
    end
  end

  // rotation chains, one cell per iteration
  for (genvar i = 0; i < N; i++) begin : g_rot
    pca_cordic_cell u_rot_a (
      .clk(clk), .en(en), .vector_mode(1'b0), .idx(5'(i)),
      .d(rot_a[i]), .q(rot_a[i+1])
    );
    pca_cordic_cell u_rot_b (
      .clk(clk), .en(en), .vector_mode(1'b0), .idx(5'(i)),
      .d(rot_b[i]), .q(rot_b[i+1])
    );
  end

  // combine stage: undo the half turn, sum or difference, equality compare
  logic signed [XW-1:0] xa;
  logic signed [XW-1:0] ya;
  logic signed [XW-1:0] xb;
  logic signed [XW-1:0] yb;
  logic signed [XW-1:0] dcos;
  logic signed [XW-1:0] dsin;
  logic                 eq_c;
  logic signed [XW-1:0] sum_x;
  logic signed [XW-1:0] sum_y;

  always_comb begin
    xa   = sd[N+2].flip_a ? -rot_a[N].x : rot_a[N].x;
    ya   = sd[N+2].flip_a ? -rot_a[N].y : rot_a[N].y;
    xb   = sd[N+2].flip_b ? -rot_b[N].x : rot_b[N].x;
    yb   = sd[N+2].flip_b ? -rot_b[N].y : rot_b[N].y;
    dcos = (xa >>> 14) - (xb >>> 14);
    dsin = (ya >>> 14) - (yb >>> 14);
    eq_c = (sd[N+2].kind == OP_EQUAL) && sd[N+2].rmatch &&
           (dcos <= XW'(EQUAL_TOLERANCE_LSB)) && (dcos >= -XW'(EQUAL_TOLERANCE_LSB)) &&
           (dsin <= XW'(EQUAL_TOLERANCE_LSB)) && (dsin >= -XW'(EQUAL_TOLERANCE_LSB));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_x <= (sd[N+2].kind == OP_SUB) ? (xa - xb) : (xa + xb);
      sum_y <= (sd[N+2].kind == OP_SUB) ? (ya - yb) : (ya + yb);
    end
  end

  // vectoring start: left half plane turned by pi
  cvec_t vec [0:N];
  logic  vzero_c;

  assign vzero_c = (sum_x == '0) && (sum_y == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (sum_x[XW-1]) begin
        vec[0] <= '{x: -sum_x, y: -sum_y, z: (sum_y[XW-1] ? -PI_Q30 : PI_Q30)};
      end else begin
        vec[0] <= '{x: sum_x, y: sum_y, z: '0};
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    pca_cordic_cell u_vec (
      .clk(clk), .en(en), .vector_mode(1'b1), .idx(5'(i)),
      .d(vec[i]), .q(vec[i+1])
    );
  end

  // magnitude gain correction and angle rescale
  logic [XW-16:0] xs;
  logic [XW+14:0] cprod;
  logic           c_over;

  always_comb begin
    xs     = vec[N].x[XW-1] ? '0 : vec[N].x[XW-2:14];
    cprod  = xs * K_Q30;
    c_over = |cprod[XW+14:62];
  end

  // radius divider chain, one quotient bit per cell
  dstep_t dv [0:DIV_BITS];

  assign dv[0] = '{rem: '0, dq: {in_q.ra, 16'h0000}, dvs: in_q.rb};

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    pca_div_cell u_div (.clk(clk), .en(en), .d(dv[j]), .q(dv[j+1]));
  end

  // sideband line; late results are dropped in at their own stages
  for (genvar k = 1; k <= LAT; k++) begin : g_side
    if (k == 1) begin : g_first
      assign sd_next[k] = s1_next;
    end else begin : g_rest
      always_comb begin
        sd_next[k] = sd[k-1];
        if (k == 2) begin
          sd_next[k].flip_a = fa[ZW];
          sd_next[k].flip_b = fb[ZW];
        end
        if (k == POS_CMB) begin
          sd_next[k].eq = eq_c;
        end
        if (k == POS_PRE) begin
          sd_next[k].vzero = vzero_c;
        end
        if (k == DIV_AT) begin
          if (sd[k-1].kind == OP_DIV && !sd[k-1].dz) begin
            sd_next[k].rad = (|dv[DIV_BITS].dq[DIV_BITS-1:32]) ? 32'hFFFFFFFF :
                             dv[DIV_BITS].dq[31:0];
            sd_next[k].sat = sd[k-1].sat || (|dv[DIV_BITS].dq[DIV_BITS-1:32]);
          end
        end
        if (k == CORD_AT) begin
          if (sd[k-1].kind == OP_ADD || sd[k-1].kind == OP_SUB) begin
            if (sd[k-1].vzero) begin
              sd_next[k].rad = '0;
              sd_next[k].ang = '0;
              sd_next[k].sat = 1'b0;
            end else begin
              sd_next[k].rad = c_over ? 32'hFFFFFFFF : cprod[61:30];
              sd_next[k].ang = vec[N].z[ZW-1:4];
              sd_next[k].sat = c_over;
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[k].valid <= 1'b0;
      end else if (en) begin
        sd[k] <= sd_next[k];
      end
    end
  end

  // result register is the last sideband stage
  assign res_valid      = sd[LAT].valid;
  assign result_radius  = sd[LAT].rad;
  assign result_angle   = sd[LAT].ang;
  assign is_equal       = sd[LAT].eq;
  assign div_by_zero    = sd[LAT].dz;
  assign saturated      = sd[LAT].sat;
  assign angle_extended = (sd[LAT].ang > TWO_PI_Q26) || (sd[LAT].ang < -TWO_PI_Q26);

`ifndef SYNTHESIS
  // a zero divisor gives a zero result and no other flag
  a_dz_zero : assert property (@(posedge clk) disable iff (rst)
    res_valid && div_by_zero |-> result_radius == '0 && result_angle == '0 && !is_equal)
    else $error("zero divisor result not cleared");

  // an equality result carries no radius, angle or saturation
  a_eq_clean : assert property (@(posedge clk) disable iff (rst)
    res_valid && is_equal |-> result_radius == '0 && !saturated && !angle_extended)
    else $error("equal result carries payload");
`endif

endmodule

// File: bench/polar_complex_alu_tb.sv
// self-checking testbench for the polar complex alu: directed and random operand streams
module polar_complex_alu_tb import pca_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // fixed-point constants of the polar arithmetic, q.30 unless marked
  localparam longint PI30      = 64'sd3373259426;
  localparam longint HALF_PI30 = 64'sd1686629713;
  localparam longint TWO_PI30  = 64'sd6746518852;
  localparam longint PI26      = 64'sd210828714;
  localparam longint TWO_PI26  = 64'sd421657428;
  localparam longint GAIN30    = 64'sd652032874;
  localparam int     DRAIN     = 120;       // cycles after the last result, well past latency
  localparam int     MAX_CYCLES = 600000;   // timeout on the whole run

  localparam longint ARCTAN [30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};

  typedef struct {
    logic [2:0]         kind;
    logic [31:0]        ra;
    logic signed [31:0] aa;
    logic [31:0]        rb;
    logic signed [31:0] ab;
  } operands_t;

  typedef struct {
    logic [31:0]        radius;
    logic signed [31:0] angle;
    logic               eq;
    logic               dz;
    logic               ext;
    logic               sat;
  } polar_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               op_valid = 1'b0;
  logic               op_stall;
  logic [2:0]         kind = '0;
  logic [31:0]        radius_a = '0;
  logic signed [31:0] angle_a = '0;
  logic [31:0]        radius_b = '0;
  logic signed [31:0] angle_b = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic [31:0]        result_radius;
  logic signed [31:0] result_angle;
  logic               is_equal;
  logic               div_by_zero;
  logic               angle_extended;
  logic               saturated;

  polar_complex_alu dut (.*);

  always #5 clk = ~clk;

  polar_result_t pending_results[$];
  int            n_errors = 0;
  int            cycles = 0;
  bit            gaps_on = 1'b1;   // cleared for stretches of back-to-back traffic

  // ---------------------------------------------------------------------------
  // predictor of the polar arithmetic
  // ---------------------------------------------------------------------------

  // polar (q16.16 radius, q5.26 angle) to rectangular q.30 by cordic rotation
  function automatic void rotate_to_rect(input logic [31:0] radius,
                                         input logic signed [31:0] angle,
                                         output longint x, output longint y);
    longint z, dx, dy;
    bit     flip;
    z    = longint'(angle) * 16;
    z    = z % TWO_PI30;           // truncating remainder, as in the datapath
    flip = 1'b0;
    if (z > PI30) z -= TWO_PI30;
    if (z < -PI30) z += TWO_PI30;
    if (z > HALF_PI30) begin
      z -= PI30;
      flip = 1'b1;
    end else if (z < -HALF_PI30) begin
      z += PI30;
      flip = 1'b1;
    end
    x = longint'(({32'b0, radius} * 64'(GAIN30)) >> 16);
    y = 0;
    for (int i = 0; i < NSTG; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
  endfunction

  // rectangular q.30 back to magnitude (unclamped q16.16) and atan2 (q5.26)
  function automatic void vector_to_polar(input longint xi, input longint yi,
                                          output logic [63:0] rad, output longint ang);
    longint      x, y, z, dx, dy;
    logic [63:0] prod;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) begin
      rad = '0;
      ang = 0;
      return;
    end
    if (x < 0) begin
      z = (y >= 0) ? PI30 : -PI30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NSTG; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    if (x < 0) x = 0;
    prod = (64'(x) >> 14) * 64'(GAIN30);   // wraps at 64 bits for huge sums
    rad  = prod >> 30;
    ang  = z >>> 4;
  endfunction

  function automatic polar_result_t polar_alu_predict(input operands_t op);
    polar_result_t r;
    logic [63:0]   rad;
    longint        ang, xa, ya, xb, yb, ca, sa, cb, sb, dr;
    rad = '0;
    ang = 0;
    r   = '{default: '0};
    case (op.kind) inside
      OP_ADD, OP_SUB: begin
        rotate_to_rect(op.ra, op.aa, xa, ya);
        rotate_to_rect(op.rb, op.ab, xb, yb);
        if (op.kind == OP_ADD) vector_to_polar(xa + xb, ya + yb, rad, ang);
        else                   vector_to_polar(xa - xb, ya - yb, rad, ang);
      end
      OP_MUL: begin
        rad = ({32'b0, op.ra} * {32'b0, op.rb}) >> 16;
        ang = longint'(op.aa) + longint'(op.ab);
      end
      OP_DIV: begin
        if (op.rb == 0) r.dz = 1'b1;
        else begin
          rad = ({32'b0, op.ra} << 16) / {32'b0, op.rb};
          ang = longint'(op.aa) - longint'(op.ab);
        end
      end
      OP_NEG: begin
        rad = {32'b0, op.ra};
        ang = longint'(op.aa) + PI26;
      end
      OP_EQUAL: begin
        rotate_to_rect(ONE_Q16, op.aa, ca, sa);
        rotate_to_rect(ONE_Q16, op.ab, cb, sb);
        ca = ca >>> 14; sa = sa >>> 14;
        cb = cb >>> 14; sb = sb >>> 14;
        dr = longint'(op.ra) - longint'(op.rb);
        r.eq = (dr <= EQUAL_TOLERANCE_LSB && -dr <= EQUAL_TOLERANCE_LSB) &&
               (ca - cb <= EQUAL_TOLERANCE_LSB && cb - ca <= EQUAL_TOLERANCE_LSB) &&
               (sa - sb <= EQUAL_TOLERANCE_LSB && sb - sa <= EQUAL_TOLERANCE_LSB);
      end
      default: ;
    endcase
    // saturation of radius and angle
    if (rad > 64'hFFFF_FFFF) begin
      rad   = 64'hFFFF_FFFF;
      r.sat = 1'b1;
    end
    if (ang > 64'sd2147483647) begin
      ang   = 64'sd2147483647;
      r.sat = 1'b1;
    end else if (ang < -64'sd2147483648) begin
      ang   = -64'sd2147483648;
      r.sat = 1'b1;
    end
    r.ext    = (ang > TWO_PI26) || (ang < -TWO_PI26);
    r.radius = rad[31:0];
    r.angle  = ang[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (!gaps_on || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one transaction and hold it until accepted
  task automatic send_op(input operands_t op);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk) op_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    kind     <= op.kind;
    radius_a <= op.ra;
    angle_a  <= op.aa;
    radius_b <= op.rb;
    angle_b  <= op.ab;
    op_valid <= 1'b1;
    do @(posedge clk); while (op_stall);
    pending_results.push_back(polar_alu_predict(op));
  endtask

  task automatic send_fields(input logic [2:0] k, input logic [31:0] ra,
                             input logic signed [31:0] aa, input logic [31:0] rb,
                             input logic signed [31:0] ab);
    operands_t op;
    op = '{k, ra, aa, rb, ab};
    send_op(op);
  endtask

  // radius with a bias towards zero, one, tiny and full scale values
  function automatic logic [31:0] pick_radius();
    case ($urandom_range(0, 9)) inside
      0:       return $urandom_range(0, 3);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2:       return ONE_Q16;
      3, 4:    return $urandom_range(0, 32'h000F_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // angle with a bias towards the fold points and the 2pi boundary
  function automatic logic signed [31:0] pick_angle();
    int m;
    m = int'($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 7)) inside
      0:       return 32'(longint'(m) * (PI26 / 2) + $urandom_range(0, 6) - 3);
      1:       return 32'(longint'(m[0] ? TWO_PI26 : -TWO_PI26) + $urandom_range(0, 4) - 2);
      2:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 3)
                                           : 32'sh80000000 + $urandom_range(0, 3);
      3, 4:    return 32'(longint'($urandom_range(0, 2 * 421657428)) - TWO_PI26);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input logic [2:0] k);
    operands_t op;
    op.kind = k;
    op.ra   = pick_radius();
    op.aa   = pick_angle();
    op.rb   = pick_radius();
    op.ab   = pick_angle();
    if (k == OP_EQUAL && $urandom_range(0, 1)) begin
      // near-matching pair, angle possibly a full turn away
      op.rb = op.ra + $urandom_range(0, 10) - 5;
      op.ab = 32'(longint'(op.aa) + ($urandom_range(0, 1) ? TWO_PI26 : 0) +
                  $urandom_range(0, 40) - 20);
    end
    if (k == OP_DIV && $urandom_range(0, 9) == 0) op.rb = '0;
    send_op(op);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    send_fields(OP_ADD, ONE_Q16, 0, ONE_Q16, 0);
    send_fields(OP_ADD, ONE_Q16, 0, ONE_Q16, 32'(PI26));          // zero sum vector
    send_fields(OP_SUB, 32'hFFFF_FFFF, 32'sh7FFFFFFF, 32'hFFFF_FFFF, 32'sh80000000);
    send_fields(OP_SUB, 32'd12345, 32'sd1000, 32'd12345, 32'sd1000); // exact cancel
    send_fields(OP_ADD, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0);        // radius overflow
    send_fields(OP_MUL, 32'hFFFF_FFFF, 32'sh7FFFFFFF, 32'hFFFF_FFFF, 32'sh7FFFFFFF);
    send_fields(OP_MUL, 32'd0, 32'sh80000000, 32'd5, 32'sh80000000);
    send_fields(OP_MUL, ONE_Q16, 32'(TWO_PI26), ONE_Q16, 32'sd1); // just past 2pi
    send_fields(OP_DIV, 32'd7, 32'sd5, 32'd0, 32'sd9);              // zero divisor
    send_fields(OP_DIV, 32'hFFFF_FFFF, 32'sh7FFFFFFF, 32'd1, 32'sh80000000);
    send_fields(OP_DIV, 32'd1, 32'sh80000000, 32'hFFFF_FFFF, 32'sh7FFFFFFF);
    send_fields(OP_NEG, 32'hFFFF_FFFF, 32'sh7FFFFFFF, 32'hDEAD_BEEF, 32'sd3);
    send_fields(OP_NEG, 32'd0, 32'sh80000000, 32'd0, 0);
    send_fields(OP_NEG, 32'd99, 32'(TWO_PI26 - PI26), 32'd0, 0);    // lands on 2pi
    send_fields(OP_EQUAL, ONE_Q16, 32'sd777, ONE_Q16, 32'sd777);
    send_fields(OP_EQUAL, ONE_Q16, 0, ONE_Q16 + 4, 32'(TWO_PI26));  // full turn apart
    send_fields(OP_EQUAL, ONE_Q16, 0, ONE_Q16 + 5, 0);
    send_fields(OP_EQUAL, 32'hFFFF_FFFF, 32'sh7FFFFFFF, 32'd0, 32'sh80000000);
    send_fields(3'd6, 32'hFFFF_FFFF, 32'sh7FFFFFFF, 32'hFFFF_FFFF, 32'sh7FFFFFFF);
    send_fields(3'd7, 32'd1, 32'sh80000000, 32'd1, 32'sh80000000);
    send_fields(OP_ADD, 32'd1, 32'(HALF_PI30 / 16 + 1), 32'd1, 32'(-(HALF_PI30 / 16) - 1));
  endtask

  task automatic test_rotation_ops();
    repeat (350) send_random($urandom_range(0, 1) ? OP_ADD : OP_SUB);
  endtask

  task automatic test_mul_div();
    repeat (300) send_random($urandom_range(0, 1) ? OP_MUL : OP_DIV);
  endtask

  task automatic test_neg_equal();
    repeat (250) send_random($urandom_range(0, 2) == 0 ? OP_NEG : OP_EQUAL);
  endtask

  // mixed operations, including the unused codes, in bursts with and without gaps
  task automatic test_mixed();
    for (int blk = 0; blk < 9; blk++) begin
      gaps_on = (blk % 3 != 1);
      repeat (50) send_random($urandom_range(0, 15) == 0 ? 3'($urandom_range(6, 7))
                                                         : 3'($urandom_range(0, 5)));
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall and checking
  // ---------------------------------------------------------------------------

  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_stall  <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 99) < 30) begin
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40)
                                                 : $urandom_range(0, 2);
      res_stall  <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    polar_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (result_radius !== want.radius) begin
          $error("result_radius: expected %h actual %h", want.radius, result_radius);
          n_errors++;
        end
        if (result_angle !== want.angle) begin
          $error("result_angle: expected %h actual %h", want.angle, result_angle);
          n_errors++;
        end
        if (is_equal !== want.eq) begin
          $error("is_equal: expected %b actual %b", want.eq, is_equal);
          n_errors++;
        end
        if (div_by_zero !== want.dz) begin
          $error("div_by_zero: expected %b actual %b", want.dz, div_by_zero);
          n_errors++;
        end
        if (angle_extended !== want.ext) begin
          $error("angle_extended: expected %b actual %b", want.ext, angle_extended);
          n_errors++;
        end
        if (saturated !== want.sat) begin
          $error("saturated: expected %b actual %b", want.sat, saturated);
          n_errors++;
        end
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_directed();
    test_rotation_ops();
    test_mul_div();
    test_neg_equal();
    test_mixed();
    @(negedge clk) op_valid <= 1'b0;
    // drain, then a quiet stretch to catch any stray transaction
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
